// ===== hdl/sm83alu_pkg.sv =====
package sm83alu_pkg;

    localparam int unsigned OpWidth = 5;

    // Operation codes carried in req_type.
    localparam logic [OpWidth-1:0] OP_ADD  = 5'd0;
    localparam logic [OpWidth-1:0] OP_ADC  = 5'd1;
    localparam logic [OpWidth-1:0] OP_SUB  = 5'd2;
    localparam logic [OpWidth-1:0] OP_SBC  = 5'd3;
    localparam logic [OpWidth-1:0] OP_AND  = 5'd4;
    localparam logic [OpWidth-1:0] OP_XOR  = 5'd5;
    localparam logic [OpWidth-1:0] OP_OR   = 5'd6;
    localparam logic [OpWidth-1:0] OP_CP   = 5'd7;
    localparam logic [OpWidth-1:0] OP_INC  = 5'd8;
    localparam logic [OpWidth-1:0] OP_DEC  = 5'd9;
    localparam logic [OpWidth-1:0] OP_CPL  = 5'd10;
    localparam logic [OpWidth-1:0] OP_RLC  = 5'd11;
    localparam logic [OpWidth-1:0] OP_RRC  = 5'd12;
    localparam logic [OpWidth-1:0] OP_RL   = 5'd13;
    localparam logic [OpWidth-1:0] OP_RR   = 5'd14;
    localparam logic [OpWidth-1:0] OP_SLA  = 5'd15;
    localparam logic [OpWidth-1:0] OP_SRA  = 5'd16;
    localparam logic [OpWidth-1:0] OP_SWAP = 5'd17;
    localparam logic [OpWidth-1:0] OP_SRL  = 5'd18;
    localparam logic [OpWidth-1:0] OP_BIT  = 5'd19;
    localparam logic [OpWidth-1:0] OP_RES  = 5'd20;
    localparam logic [OpWidth-1:0] OP_SET  = 5'd21;

    typedef struct packed {
        logic [OpWidth-1:0] req_type;
        logic [7:0]         operand_a;
        logic [7:0]         operand_b;
        logic [2:0]         bit_index;
    } t_req;

    typedef struct packed {
        logic [7:0] result;
        logic       writes_result;
        logic       flag_zero;
        logic       flag_subtract;
        logic       flag_half_carry;
        logic       flag_carry;
    } t_rsp;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

endpackage

// ===== hdl/sm83alu_exec.sv =====
module sm83alu_exec (
    input  sm83alu_pkg::t_req   i_req,
    input  sm83alu_pkg::t_flags i_flags,
    output sm83alu_pkg::t_rsp   o_rsp,
    output sm83alu_pkg::t_flags o_flags
);

    logic [7:0]          a;
    logic [7:0]          b;
    logic                cin;
    logic                c_add;
    logic                c_sub;
    logic [8:0]          add_full;
    logic [4:0]          add_low;
    logic [8:0]          sub_full;
    logic [4:0]          sub_low;
    logic [7:0]          bit_mask;
    logic [7:0]          res;
    logic                wr;
    sm83alu_pkg::t_flags f;

    assign a   = i_req.operand_a;
    assign b   = i_req.operand_b;
    assign cin = i_flags.c;

    assign c_add = (i_req.req_type == sm83alu_pkg::OP_ADC) ? cin : 1'b0;
    assign c_sub = (i_req.req_type == sm83alu_pkg::OP_SBC) ? cin : 1'b0;

    // Bit 8 of the nine-bit difference is the borrow out of the byte.
    assign add_full = {1'b0, a} + {1'b0, b} + {8'd0, c_add};
    assign add_low  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_add};
    assign sub_full = {1'b0, a} - {1'b0, b} - {8'd0, c_sub};
    assign sub_low  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_sub};

    assign bit_mask = 8'h01 << i_req.bit_index;

    always_comb begin
        res = a;
        wr  = 1'b1;
        f   = i_flags;
        case (i_req.req_type)
            sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
                res = add_full[7:0];
                f   = '{z: (add_full[7:0] == 8'h00), n: 1'b0, h: add_low[4], c: add_full[8]};
            end
            sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
                res = sub_full[7:0];
                f   = '{z: (sub_full[7:0] == 8'h00), n: 1'b1, h: sub_low[4], c: sub_full[8]};
                wr  = (i_req.req_type != sm83alu_pkg::OP_CP);
            end
            sm83alu_pkg::OP_AND: begin
                res = a & b;
                f   = '{z: ((a & b) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            sm83alu_pkg::OP_XOR: begin
                res = a ^ b;
                f   = '{z: ((a ^ b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            sm83alu_pkg::OP_OR: begin
                res = a | b;
                f   = '{z: ((a | b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            sm83alu_pkg::OP_INC: begin
                res = a + 8'h01;
                f   = '{z: (a == 8'hFF), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
            end
            sm83alu_pkg::OP_DEC: begin
                res = a - 8'h01;
                f   = '{z: (a == 8'h01), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
            end
            sm83alu_pkg::OP_CPL: begin
                res = ~a;
                f   = '{z: i_flags.z, n: 1'b1, h: 1'b1, c: i_flags.c};
            end
            sm83alu_pkg::OP_RLC: begin
                res = {a[6:0], a[7]};
                f   = '{z: (a == 8'h00), n: 1'b0, h: 1'b0, c: a[7]};
            end
            sm83alu_pkg::OP_RRC: begin
                res = {a[0], a[7:1]};
                f   = '{z: (a == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
            end
            sm83alu_pkg::OP_RL: begin
                res = {a[6:0], cin};
                f   = '{z: ({a[6:0], cin} == 8'h00), n: 1'b0, h: 1'b0, c: a[7]};
            end
            sm83alu_pkg::OP_RR: begin
                res = {cin, a[7:1]};
                f   = '{z: ({cin, a[7:1]} == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
            end
            sm83alu_pkg::OP_SLA: begin
                res = {a[6:0], 1'b0};
                f   = '{z: (a[6:0] == 7'h00), n: 1'b0, h: 1'b0, c: a[7]};
            end
            sm83alu_pkg::OP_SRA: begin
                res = {a[7], a[7:1]};
                f   = '{z: (a[7:1] == 7'h00), n: 1'b0, h: 1'b0, c: a[0]};
            end
            sm83alu_pkg::OP_SWAP: begin
                res = {a[3:0], a[7:4]};
                f   = '{z: (a == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            sm83alu_pkg::OP_SRL: begin
                res = {1'b0, a[7:1]};
                f   = '{z: (a[7:1] == 7'h00), n: 1'b0, h: 1'b0, c: a[0]};
            end
            sm83alu_pkg::OP_BIT: begin
                wr = 1'b0;
                f  = '{z: ((a & bit_mask) == 8'h00), n: 1'b0, h: 1'b1, c: cin};
            end
            sm83alu_pkg::OP_RES: begin
                res = a & ~bit_mask;
            end
            sm83alu_pkg::OP_SET: begin
                res = a | bit_mask;
            end
            default: begin
                // Unused codes pass the operand through and leave the flags alone.
                wr = 1'b0;
            end
        endcase
    end

    assign o_flags = f;
    assign o_rsp   = '{result: res, writes_result: wr, flag_zero: f.z,
                       flag_subtract: f.n, flag_half_carry: f.h, flag_carry: f.c};

endmodule

// ===== hdl/sm83_alu_with_flags_core.sv =====
// SM83 8-bit ALU with its Z, N, H and C flag register.
// Requests arrive on the input channel (i_valid / o_ready, payload i_req) and
// results leave on the output channel (o_valid / i_ready, payload o_rsp).
// A transaction is taken at a rising edge with valid and ready both high.
// Each request is captured in an input register; the ALU and flag logic sit
// between that register and the result register, which presents the result
// on o_rsp. Throughput is one transaction per cycle while the receiver
// keeps i_ready high. The flag register is updated as a request moves into
// the result register, so the next request, one stage behind, sees the
// carry that the previous one left.
// When the receiver stalls, the result register holds its transaction and the
// input register fills behind it; o_ready then drops until the result is
// taken.
// A synchronous active-low reset empties both stages and clears all flags.
module sm83_alu_with_flags_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sm83alu_pkg::t_req   i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output sm83alu_pkg::t_rsp   o_rsp
);

    logic                r_in_valid;
    sm83alu_pkg::t_req   r_in;
    logic                r_out_valid;
    sm83alu_pkg::t_rsp   r_out;
    sm83alu_pkg::t_flags r_flags;

    sm83alu_pkg::t_rsp   n_out;
    sm83alu_pkg::t_flags n_flags;
    logic                advance;

    sm83alu_exec u_exec (
        .i_req   (r_in),
        .i_flags (r_flags),
        .o_rsp   (n_out),
        .o_flags (n_flags)
    );

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_flags <= n_flags;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_req;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== sim/sm83_alu_with_flags_core_tb.sv =====
`timescale 1ns / 1ps

class alu_scoreboard;
    sm83alu_pkg::t_flags flags;
    sm83alu_pkg::t_rsp   expected_results[$];
    int unsigned         mismatch_count;

    function new();
        flags = '0;
        mismatch_count = 0;
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    // Works out the result of one operation and moves the flag register on.
    function sm83alu_pkg::t_rsp predict_alu(sm83alu_pkg::t_req req);
        logic [7:0]          a;
        logic [7:0]          b;
        logic [7:0]          res;
        logic [8:0]          wide;
        logic [4:0]          nib;
        logic                cin;
        logic                cuse;
        logic                wr;
        sm83alu_pkg::t_flags nf;
        a   = req.operand_a;
        b   = req.operand_b;
        cin = flags.c;
        nf  = flags;
        res = a;
        wr  = 1'b1;
        case (req.req_type)
            sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
                cuse = (req.req_type == sm83alu_pkg::OP_ADC) & cin;
                wide = {1'b0, a} + {1'b0, b} + {8'h00, cuse};
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cuse};
                res  = wide[7:0];
                nf   = {res == 8'h00, 1'b0, nib[4], wide[8]};
            end
            sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
                // The top bit of each difference is set exactly when it borrows.
                cuse = (req.req_type == sm83alu_pkg::OP_SBC) & cin;
                wide = {1'b0, a} - {1'b0, b} - {8'h00, cuse};
                nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cuse};
                res  = wide[7:0];
                nf   = {res == 8'h00, 1'b1, nib[4], wide[8]};
                wr   = (req.req_type != sm83alu_pkg::OP_CP);
            end
            sm83alu_pkg::OP_AND: begin
                res = a & b;
                nf  = {res == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            sm83alu_pkg::OP_XOR: begin
                res = a ^ b;
                nf  = {res == 8'h00, 3'b000};
            end
            sm83alu_pkg::OP_OR: begin
                res = a | b;
                nf  = {res == 8'h00, 3'b000};
            end
            sm83alu_pkg::OP_INC: begin
                res = a + 8'h01;
                nf  = {res == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
            end
            sm83alu_pkg::OP_DEC: begin
                res = a - 8'h01;
                nf  = {res == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
            end
            sm83alu_pkg::OP_CPL: begin
                res = ~a;
                nf  = {flags.z, 1'b1, 1'b1, flags.c};
            end
            sm83alu_pkg::OP_RLC: begin
                res = {a[6:0], a[7]};
                nf  = {res == 8'h00, 2'b00, a[7]};
            end
            sm83alu_pkg::OP_RRC: begin
                res = {a[0], a[7:1]};
                nf  = {res == 8'h00, 2'b00, a[0]};
            end
            sm83alu_pkg::OP_RL: begin
                res = {a[6:0], cin};
                nf  = {res == 8'h00, 2'b00, a[7]};
            end
            sm83alu_pkg::OP_RR: begin
                res = {cin, a[7:1]};
                nf  = {res == 8'h00, 2'b00, a[0]};
            end
            sm83alu_pkg::OP_SLA: begin
                res = {a[6:0], 1'b0};
                nf  = {res == 8'h00, 2'b00, a[7]};
            end
            sm83alu_pkg::OP_SRA: begin
                res = {a[7], a[7:1]};
                nf  = {res == 8'h00, 2'b00, a[0]};
            end
            sm83alu_pkg::OP_SWAP: begin
                res = {a[3:0], a[7:4]};
                nf  = {res == 8'h00, 3'b000};
            end
            sm83alu_pkg::OP_SRL: begin
                res = {1'b0, a[7:1]};
                nf  = {res == 8'h00, 2'b00, a[0]};
            end
            sm83alu_pkg::OP_BIT: begin
                wr = 1'b0;
                nf = {~a[req.bit_index], 1'b0, 1'b1, cin};
            end
            sm83alu_pkg::OP_RES: res = a & ~(8'h01 << req.bit_index);
            sm83alu_pkg::OP_SET: res = a | (8'h01 << req.bit_index);
            default: wr = 1'b0;
        endcase
        flags = nf;
        return {res, wr, nf};
    endfunction

    function void note_request(sm83alu_pkg::t_req req);
        expected_results.push_back(predict_alu(req));
    endfunction

    task report_mismatch(string msg);
        mismatch_count++;
        $display("at %0t: %s", $time, msg);
    endtask

    task check_response(sm83alu_pkg::t_rsp got);
        sm83alu_pkg::t_rsp want;
        if (expected_results.size() == 0) begin
            report_mismatch("result transaction arrived with nothing expected");
            return;
        end
        want = expected_results.pop_front();
        if (got.result !== want.result)
            report_mismatch($sformatf("result %02h, expected %02h", got.result, want.result));
        if (got.writes_result !== want.writes_result)
            report_mismatch($sformatf("writes_result %b, expected %b",
                got.writes_result, want.writes_result));
        if (got.flag_zero !== want.flag_zero)
            report_mismatch($sformatf("flag_zero %b, expected %b",
                got.flag_zero, want.flag_zero));
        if (got.flag_subtract !== want.flag_subtract)
            report_mismatch($sformatf("flag_subtract %b, expected %b",
                got.flag_subtract, want.flag_subtract));
        if (got.flag_half_carry !== want.flag_half_carry)
            report_mismatch($sformatf("flag_half_carry %b, expected %b",
                got.flag_half_carry, want.flag_half_carry));
        if (got.flag_carry !== want.flag_carry)
            report_mismatch($sformatf("flag_carry %b, expected %b",
                got.flag_carry, want.flag_carry));
    endtask
endclass

module sm83_alu_with_flags_core_tb;

    localparam int unsigned CycleLimit = 200000;
    // Operation codes above the last defined one do nothing.
    localparam logic [4:0]  UnusedFirst = 5'd22;
    localparam logic [4:0]  UnusedLast  = 5'd31;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    sm83alu_pkg::t_req   i_req   = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    sm83alu_pkg::t_rsp   o_rsp;

    alu_scoreboard board;
    logic          calm         = 1'b0;
    logic          hold_request = 1'b0;
    int unsigned   hold_left    = 0;
    int unsigned   cycle_count  = 0;

    sm83_alu_with_flags_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Both channels are sampled here with the values they held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                board.note_request(i_req);
            end
            if (o_valid && i_ready) begin
                board.check_response(o_rsp);
            end
        end
    end

    // Receiver: random back-pressure, with a long hold-off when asked for one.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 7);
        end
    end

    function automatic sm83alu_pkg::t_req make_req(logic [4:0] op, logic [7:0] a,
                                                   logic [7:0] b, logic [2:0] idx);
        sm83alu_pkg::t_req req;
        req.req_type  = op;
        req.operand_a = a;
        req.operand_b = b;
        req.bit_index = idx;
        return req;
    endfunction

    // Operands lean towards the nibble and sign boundaries now and then.
    function automatic logic [7:0] pick_operand();
        logic [7:0] corners[6];
        corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h01};
        if ($urandom_range(0, 99) < 20) begin
            return corners[$urandom_range(0, 5)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic sm83alu_pkg::t_req random_req();
        logic [4:0] op;
        if ($urandom_range(0, 99) < 5) begin
            op = 5'($urandom_range(UnusedFirst, UnusedLast));
        end else begin
            op = 5'($urandom_range(sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_SET));
        end
        return make_req(op, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)));
    endfunction

    task automatic send_request(input sm83alu_pkg::t_req req);
        if (!calm && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Random operations until the given number of real ones has gone in;
    // unused codes are sent but not counted.
    task automatic send_random(input int unsigned amount);
        int unsigned       sent;
        sm83alu_pkg::t_req req;
        sent = 0;
        while (sent < amount) begin
            req = random_req();
            send_request(req);
            if (req.req_type <= sm83alu_pkg::OP_SET) begin
                sent++;
            end
        end
    endtask

    // The first edge lets the monitor note the last accepted request.
    task automatic wait_drained();
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_req(sm83alu_pkg::OP_ADD, 8'hFF, 8'h01, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_ADC, 8'h00, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_ADD, 8'h0F, 8'h01, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_SUB, 8'h00, 8'h01, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_SBC, 8'h10, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_SBC, 8'hFF, 8'hFF, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_CP, 8'h42, 8'h42, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_AND, 8'hF0, 8'h0F, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_XOR, 8'hA5, 8'hA5, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_OR, 8'hFF, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_INC, 8'hFF, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_DEC, 8'h00, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_DEC, 8'h01, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_CPL, 8'h5A, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_RLC, 8'h80, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_RRC, 8'h01, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_RL, 8'h80, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_RR, 8'h00, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_SLA, 8'h80, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_SRA, 8'h81, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_SWAP, 8'hF0, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_SRL, 8'h01, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_BIT, 8'h7F, 8'h00, 3'd7));
        send_request(make_req(sm83alu_pkg::OP_RES, 8'hFF, 8'h00, 3'd0));
        send_request(make_req(sm83alu_pkg::OP_SET, 8'h00, 8'h00, 3'd7));
        send_request(make_req(UnusedFirst, 8'h3C, 8'hC3, 3'd5));
        send_request(make_req(UnusedLast, 8'hFF, 8'hFF, 3'd7));

        send_random(150);

        // The receiver holds off while requests keep coming, so the pipeline
        // fills and the input side stalls; then the sender waits for it to empty.
        hold_request = 1'b1;
        send_random(30);
        i_valid <= 1'b0;
        wait_drained();

        calm = 1'b1;
        send_random(150);
        calm = 1'b0;
        send_random(180);

        i_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
